FILE: rtl/grpe_pkg.sv
// ----------------------------------------------------------------------------
// grpe_pkg
// shared types and constants for the glyph row pixel expander
// ----------------------------------------------------------------------------
package grpe_pkg;

  // glyph geometry limits
  localparam int MAX_CELL_WIDTH  = 16;
  localparam int MAX_CELL_HEIGHT = 32;

  // field widths
  localparam int X_W     = 12;
  localparam int Y_W     = 12;
  localparam int BITS_W  = 8;
  localparam int COLR_W  = 32;
  localparam int OFF_W   = 26;
  localparam int ROW_W   = 6;
  localparam int DIM_W   = 13;
  localparam int PITCH_W = 15;
  localparam int BPP_W   = 3;
  localparam int CELL_W  = 5;

  // y plus row index, enough for 4095 + MAX_CELL_HEIGHT
  localparam int YR_W = 13;

  // column counter holds 0 .. MAX_CELL_WIDTH
  localparam int CNT_W = $clog2(MAX_CELL_WIDTH + 1);

  // serial multiply: one step per bit of (y + row), then one per bit of bpp
  localparam int MUL_Y_STEPS = YR_W;
  localparam int MUL_STEPS   = YR_W + BPP_W;
  localparam int STEP_W      = $clog2(MUL_STEPS);

  // leftmost glyph pixel
  localparam logic [BITS_W-1:0] INK_MASK = 8'h80;

  // apb register file
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [ADDR_W-3:0] {
    REG_SURFACE_PRESENT = 3'd0,
    REG_SURFACE_WIDTH   = 3'd1,
    REG_SURFACE_HEIGHT  = 3'd2,
    REG_ROW_PITCH       = 3'd3,
    REG_PIXEL_BYTES     = 3'd4,
    REG_CELL_WIDTH      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               surface_present;
    logic [DIM_W-1:0]   surface_width;
    logic [DIM_W-1:0]   surface_height;
    logic [PITCH_W-1:0] row_pitch;
    logic [BPP_W-1:0]   pixel_bytes;
    logic [CELL_W-1:0]  cell_width;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0]    origin_x;
    logic [Y_W-1:0]    origin_y;
    logic [BITS_W-1:0] row_bits;
    logic [COLR_W-1:0] ink_color;
    logic [COLR_W-1:0] paper_color;
    logic              last_row;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  byte_offset;
    logic [COLR_W-1:0] pixel_value;
    logic              last_pixel;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/grpe_in_if.sv
// ----------------------------------------------------------------------------
// grpe_in_if
// glyph row channel: valid, ready and one glyph row item
// ----------------------------------------------------------------------------
interface grpe_in_if;
  logic               valid;
  logic               ready;
  grpe_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/grpe_out_if.sv
// ----------------------------------------------------------------------------
// grpe_out_if
// pixel write channel: valid, ready and one pixel write item
// ----------------------------------------------------------------------------
interface grpe_out_if;
  logic                valid;
  logic                ready;
  grpe_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/grpe_cfg_regs.sv
// ----------------------------------------------------------------------------
// grpe_cfg_regs
// apb register file holding the surface and cell configuration
// ----------------------------------------------------------------------------
module grpe_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grpe_pkg::ADDR_W-1:0] paddr,
  input  logic [grpe_pkg::DATA_W-1:0] pwdata,
  output logic [grpe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output grpe_pkg::cfg_t              cfg
);

  grpe_pkg::cfg_t   cfg_r;
  grpe_pkg::cfg_t   cfg_nxt;
  grpe_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = grpe_pkg::reg_idx_t'(paddr[grpe_pkg::ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        grpe_pkg::REG_SURFACE_PRESENT: cfg_nxt.surface_present = pwdata[0];
        grpe_pkg::REG_SURFACE_WIDTH:
          cfg_nxt.surface_width = pwdata[grpe_pkg::DIM_W-1:0];
        grpe_pkg::REG_SURFACE_HEIGHT:
          cfg_nxt.surface_height = pwdata[grpe_pkg::DIM_W-1:0];
        grpe_pkg::REG_ROW_PITCH: cfg_nxt.row_pitch = pwdata[grpe_pkg::PITCH_W-1:0];
        grpe_pkg::REG_PIXEL_BYTES:
          cfg_nxt.pixel_bytes = pwdata[grpe_pkg::BPP_W-1:0];
        grpe_pkg::REG_CELL_WIDTH: cfg_nxt.cell_width = pwdata[grpe_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      grpe_pkg::REG_SURFACE_PRESENT:
        prdata = grpe_pkg::DATA_W'(cfg_r.surface_present);
      grpe_pkg::REG_SURFACE_WIDTH:   prdata = grpe_pkg::DATA_W'(cfg_r.surface_width);
      grpe_pkg::REG_SURFACE_HEIGHT:  prdata = grpe_pkg::DATA_W'(cfg_r.surface_height);
      grpe_pkg::REG_ROW_PITCH:       prdata = grpe_pkg::DATA_W'(cfg_r.row_pitch);
      grpe_pkg::REG_PIXEL_BYTES:
        prdata = grpe_pkg::DATA_W'(cfg_r.pixel_bytes);
      grpe_pkg::REG_CELL_WIDTH:      prdata = grpe_pkg::DATA_W'(cfg_r.cell_width);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_present <= 1'b0;
      cfg_r.surface_width   <= '0;
      cfg_r.surface_height  <= '0;
      cfg_r.row_pitch       <= '0;
      cfg_r.pixel_bytes     <= grpe_pkg::BPP_W'(4);
      cfg_r.cell_width      <= grpe_pkg::CELL_W'(8);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/glyph_row_pixel_expander_unit.sv
// ----------------------------------------------------------------------------
// glyph_row_pixel_expander_unit
// expands one 1-bit glyph row into clipped framebuffer pixel writes
// ----------------------------------------------------------------------------
// a visible row is accepted in idle, then the bit-serial shift-add multiplier
//   forms its byte offset before its first pixel write is offered
// throughput: one pixel write per cycle while out_ch is not stalled; a new row is
//   taken only once the last write of the row has been issued, a fully clipped row
//   is dropped at acceptance and the block stays idle
// reset: synchronous, active low; clears fsm, row, step and column counters and output valid, not the datapath
module glyph_row_pixel_expander_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  grpe_in_if.sink                     in_ch,
  grpe_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grpe_pkg::ADDR_W-1:0] paddr,
  input  logic [grpe_pkg::DATA_W-1:0] pwdata,
  output logic [grpe_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  grpe_pkg::cfg_t cfg;

  grpe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control state
  grpe_pkg::state_t              state_r, state_nxt;
  logic [grpe_pkg::ROW_W-1:0]    row_idx_r, row_idx_nxt;
  logic [grpe_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [grpe_pkg::CNT_W-1:0]    cols_left_r, cols_left_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // datapath
  logic [grpe_pkg::X_W-1:0]      x_r, x_nxt;
  logic [grpe_pkg::BITS_W-1:0]   bits_r, bits_nxt;
  logic [grpe_pkg::COLR_W-1:0]   ink_r, ink_nxt;
  logic [grpe_pkg::COLR_W-1:0]   paper_r, paper_nxt;
  logic [grpe_pkg::YR_W-1:0]     mplr_r, mplr_nxt;
  logic [grpe_pkg::OFF_W-1:0]    mcand_r, mcand_nxt;
  logic [grpe_pkg::OFF_W-1:0]    acc_r, acc_nxt;
  grpe_pkg::out_item_t           out_data_r, out_data_nxt;

  // row qualification, evaluated on the accepted item
  logic                          accept;
  logic                          load;
  logic [grpe_pkg::YR_W-1:0]     y_row;
  logic [grpe_pkg::DIM_W-1:0]    x_ext;
  logic [grpe_pkg::DIM_W-1:0]    width_left;
  logic [grpe_pkg::CNT_W-1:0]    cell_clamp;
  logic [grpe_pkg::CNT_W-1:0]    cols;
  logic                          row_visible;

  assign in_ch.ready  = (state_r == grpe_pkg::ST_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // output register is free when empty or being drained this cycle
  assign load = !out_valid_r || out_ch.ready;

  assign y_row = grpe_pkg::YR_W'(in_ch.data.origin_y) + grpe_pkg::YR_W'(row_idx_r);
  assign x_ext = grpe_pkg::DIM_W'(in_ch.data.origin_x);
  assign width_left = cfg.surface_width - x_ext;

  always_comb begin
    if (grpe_pkg::CNT_W'(cfg.cell_width) > grpe_pkg::CNT_W'(grpe_pkg::MAX_CELL_WIDTH)) begin
      cell_clamp = grpe_pkg::CNT_W'(grpe_pkg::MAX_CELL_WIDTH);
    end else begin
      cell_clamp = grpe_pkg::CNT_W'(cfg.cell_width);
    end
    // clip to the columns left before the right edge
    if (width_left < grpe_pkg::DIM_W'(cell_clamp)) begin
      cols = width_left[grpe_pkg::CNT_W-1:0];
    end else begin
      cols = cell_clamp;
    end
  end

  assign row_visible = cfg.surface_present
                    && (row_idx_r < grpe_pkg::ROW_W'(grpe_pkg::MAX_CELL_HEIGHT))
                    && (y_row < cfg.surface_height)
                    && (x_ext < cfg.surface_width)
                    && (cols != '0);

  always_comb begin
    state_nxt     = state_r;
    row_idx_nxt   = row_idx_r;
    step_nxt      = step_r;
    cols_left_nxt = cols_left_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    x_nxt         = x_r;
    bits_nxt      = bits_r;
    ink_nxt       = ink_r;
    paper_nxt     = paper_r;
    mplr_nxt      = mplr_r;
    mcand_nxt     = mcand_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      grpe_pkg::ST_IDLE: begin
        if (accept) begin
          // row counter moves on every row, visible or not
          if (in_ch.data.last_row) begin
            row_idx_nxt = '0;
          end else if (row_idx_r < grpe_pkg::ROW_W'(grpe_pkg::MAX_CELL_HEIGHT)) begin
            row_idx_nxt = row_idx_r + 1'b1;
          end
          x_nxt         = in_ch.data.origin_x;
          bits_nxt      = in_ch.data.row_bits;
          ink_nxt       = in_ch.data.ink_color;
          paper_nxt     = in_ch.data.paper_color;
          mplr_nxt      = y_row;
          mcand_nxt     = grpe_pkg::OFF_W'(cfg.row_pitch);
          acc_nxt       = '0;
          step_nxt      = '0;
          cols_left_nxt = cols;
          if (row_visible) begin
            state_nxt = grpe_pkg::ST_MUL;
          end
        end
      end

      grpe_pkg::ST_MUL: begin
        // one multiplier bit per cycle, sums wrap at the offset width
        if (mplr_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mplr_nxt  = mplr_r >> 1;
        mcand_nxt = mcand_r << 1;
        step_nxt  = step_r + 1'b1;
        if (step_r == grpe_pkg::STEP_W'(grpe_pkg::MUL_Y_STEPS - 1)) begin
          // row base done, now add origin_x times the pixel size
          mplr_nxt  = grpe_pkg::YR_W'(cfg.pixel_bytes);
          mcand_nxt = grpe_pkg::OFF_W'(x_r);
        end
        if (step_r == grpe_pkg::STEP_W'(grpe_pkg::MUL_STEPS - 1)) begin
          state_nxt = grpe_pkg::ST_EMIT;
        end
      end

      grpe_pkg::ST_EMIT: begin
        if (load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.byte_offset = acc_r;
          out_data_nxt.pixel_value = ((bits_r & grpe_pkg::INK_MASK) != '0) ? ink_r : paper_r;
          out_data_nxt.last_pixel  = (cols_left_r == grpe_pkg::CNT_W'(1));
          // glyph bits shift out msb first, columns past eight see zeros
          acc_nxt       = acc_r + grpe_pkg::OFF_W'(cfg.pixel_bytes);
          bits_nxt      = bits_r << 1;
          cols_left_nxt = cols_left_r - 1'b1;
          if (cols_left_r == grpe_pkg::CNT_W'(1)) begin
            state_nxt = grpe_pkg::ST_IDLE;
          end
        end
      end

      default: state_nxt = grpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grpe_pkg::ST_IDLE;
      row_idx_r   <= '0;
      step_r      <= '0;
      cols_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_idx_r   <= row_idx_nxt;
      step_r      <= step_nxt;
      cols_left_r <= cols_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    bits_r     <= bits_nxt;
    ink_r      <= ink_nxt;
    paper_r    <= paper_nxt;
    mplr_r     <= mplr_nxt;
    mcand_r    <= mcand_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // the final column of a row hands control back for the next row
  a_last_col_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grpe_pkg::ST_EMIT && load && cols_left_r == grpe_pkg::CNT_W'(1))
    |=> (state_r == grpe_pkg::ST_IDLE && out_valid_r && out_data_r.last_pixel))
    else $error("last column did not end the row");

  // emission never runs with no columns left
  a_cols_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grpe_pkg::ST_EMIT) |-> (cols_left_r != '0))
    else $error("emitting with no columns left");

  // row counter saturates at the glyph height limit
  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
    row_idx_r <= grpe_pkg::ROW_W'(grpe_pkg::MAX_CELL_HEIGHT))
    else $error("row counter past limit");

  // a stalled pixel write is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending pixel write lost");
`endif

endmodule
